@@ sv/ial_pkg.sv @@
// ----------------------------------------------------------------------------
// ial_pkg
// Request codes, field widths and the control bundle shared by the indexed
// array list and its storage cells.
// ----------------------------------------------------------------------------
package ial_pkg;

    // fixed field widths of the request and response beats
    localparam int REQ_W   = 3;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;

    // request codes; the two unused codes fail
    typedef enum logic [REQ_W-1:0] {
        REQ_GET    = 3'd0,
        REQ_SET    = 3'd1,
        REQ_INSERT = 3'd2,
        REQ_REMOVE = 3'd3,
        REQ_PUSH   = 3'd4,
        REQ_POP    = 3'd5
    } req_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;   // open a slot at the position, later entries move up
        logic del;   // close the slot at the position, later entries move down
        logic set;   // overwrite the entry at the position
    } cell_ctrl_t;

endpackage

@@ sv/ial_req_if.sv @@
// ----------------------------------------------------------------------------
// ial_req_if
// Request channel: valid/ready handshake with request code, position and word.
// ----------------------------------------------------------------------------
interface ial_req_if
    import ial_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [POS_W-1:0]    position;
    logic [DATA_W-1:0]   data_in;

    modport source (output valid, output req_type, output position, output data_in,
                    input ready);
    modport sink   (input valid, input req_type, input position, input data_in,
                    output ready);
endinterface

@@ sv/ial_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ial_rsp_if
// Response channel: valid/ready handshake with data word, status and count.
// ----------------------------------------------------------------------------
interface ial_rsp_if
    import ial_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [DATA_W-1:0]   data_out;
    logic                ok;
    logic [COUNT_W-1:0]  count;

    modport source (output valid, output data_out, output ok, output count,
                    input ready);
    modport sink   (input valid, input data_out, input ok, input count,
                    output ready);
endinterface

@@ sv/ial_cell.sv @@
// ----------------------------------------------------------------------------
// ial_cell
// One storage slot of the list. Compares its own index with the addressed
// position and takes its left neighbor, right neighbor or the new word.
// ----------------------------------------------------------------------------
module ial_cell
    import ial_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int WORD_WIDTH = 32,
    parameter int CMP_W      = 5
)
(
    input  logic                  clk,
    input  cell_ctrl_t            ctrl,
    input  logic [CMP_W-1:0]      pos,
    input  logic [WORD_WIDTH-1:0] word,
    input  logic [WORD_WIDTH-1:0] left,
    input  logic [WORD_WIDTH-1:0] right,
    output logic [WORD_WIDTH-1:0] value
);

    logic [WORD_WIDTH-1:0] value_reg;
    logic [WORD_WIDTH-1:0] value_next;
    logic                  hit;
    logic                  above;

    // where this slot sits relative to the addressed position
    assign hit   = (pos == CMP_W'(INDEX));
    assign above = (pos <  CMP_W'(INDEX));

    // slot update
    always_comb
    begin
        value_next = value_reg;
        priority if (ctrl.ins)
        begin
            if (above)
                value_next = left;
            else if (hit)
                value_next = word;
        end
        else if (ctrl.del)
        begin
            if (above || hit)
                value_next = right;
        end
        else if (ctrl.set)
        begin
            if (hit)
                value_next = word;
        end
        else
        begin
            // idle cycle: slot holds its word
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ sv/indexed_array_list.sv @@
// ----------------------------------------------------------------------------
// indexed_array_list
// Fixed-capacity indexed list: get, set, insert, remove, push and pop.
// Response: the response beat is registered on the accepted request beat and is shown in the cycle after it.
// Throughput: one request per cycle while no untaken response waits;
// the cell row shifts the whole list on an accepted beat, one slot per cell.
// Reset: the entry count clears to zero and the response register empties;
// slot contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_array_list
    import ial_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int WORD_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    ial_req_if.sink     req,
    ial_rsp_if.source   rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    // control state
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               out_valid_reg;
    // response payload
    logic [DATA_W-1:0]  data_out_reg;
    logic [DATA_W-1:0]  data_out_next;
    logic               ok_reg;
    logic               ok_next;
    logic [COUNT_W-1:0] count_out_reg;

    logic                  accept;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      count_ext;
    logic [CMP_W-1:0]      eff_pos;
    logic                  full;
    logic                  cmd_ins;
    logic                  cmd_del;
    logic                  cmd_set;
    logic                  cmd_read;
    cell_ctrl_t            ctrl;
    logic [63:0]           word_wide;
    logic [WORD_WIDTH-1:0] word;
    logic [WORD_WIDTH-1:0] cell_val [CAPACITY];
    logic [WORD_WIDTH-1:0] rd_word;
    logic [63:0]           rd_wide;
    logic [CMP_W-1:0]      count_next_ext;

    // handshake: a waiting response only blocks if it is not being taken
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign pos_ext   = CMP_W'(req.position);
    assign count_ext = CMP_W'(count_reg);
    assign full      = (count_ext == CMP_W'(CAPACITY));

    assign word_wide = 64'(req.data_in);
    assign word      = word_wide[WORD_WIDTH-1:0];

    // request decode and bounds checks
    always_comb
    begin
        eff_pos  = pos_ext;
        cmd_ins  = 1'b0;
        cmd_del  = 1'b0;
        cmd_set  = 1'b0;
        cmd_read = 1'b0;
        unique case (req_t'(req.req_type))
            REQ_GET:
            begin
                cmd_read = (pos_ext < count_ext);
            end
            REQ_SET:
            begin
                cmd_read = (pos_ext < count_ext);
                cmd_set  = cmd_read;
            end
            REQ_INSERT:
            begin
                cmd_ins = !full && (pos_ext <= count_ext);
            end
            REQ_REMOVE:
            begin
                cmd_read = (pos_ext < count_ext);
                cmd_del  = cmd_read;
            end
            REQ_PUSH:
            begin
                eff_pos = count_ext;
                cmd_ins = !full;
            end
            REQ_POP:
            begin
                eff_pos  = count_ext - CMP_W'(1);
                cmd_read = (count_ext != '0);
                cmd_del  = cmd_read;
            end
            default:
            begin
                eff_pos = pos_ext;
            end
        endcase
    end

    // command to the cell row, only on an accepted beat
    always_comb
    begin
        ctrl.ins = accept && cmd_ins;
        ctrl.del = accept && cmd_del;
        ctrl.set = accept && cmd_set;
    end

    // row of cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [WORD_WIDTH-1:0] left_val;
        logic [WORD_WIDTH-1:0] right_val;

        if (i == 0)
        begin : g_first
            assign left_val = '0;
        end
        else
        begin : g_mid_l
            assign left_val = cell_val[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_val = '0;
        end
        else
        begin : g_mid_r
            assign right_val = cell_val[i+1];
        end

        ial_cell #(
            .INDEX      (i),
            .WORD_WIDTH (WORD_WIDTH),
            .CMP_W      (CMP_W)
        ) u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .pos   (eff_pos),
            .word  (word),
            .left  (left_val),
            .right (right_val),
            .value (cell_val[i])
        );
    end

    // read port: and-or select of the addressed slot
    always_comb
    begin
        rd_word = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (eff_pos == CMP_W'(i))
                rd_word = rd_word | cell_val[i];
        end
    end

    assign rd_wide = 64'(rd_word);

    // response contents and new count
    always_comb
    begin
        ok_next       = cmd_read || cmd_ins;
        data_out_next = cmd_read ? rd_wide[DATA_W-1:0] : '0;
        count_next    = count_reg;
        if (cmd_ins)
            count_next = count_reg + CNT_W'(1);
        else if (cmd_del)
            count_next = count_reg - CNT_W'(1);
    end

    assign count_next_ext = CMP_W'(count_next);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // response payload register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_out_reg  <= data_out_next;
            ok_reg        <= ok_next;
            count_out_reg <= count_next_ext[COUNT_W-1:0];
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.data_out = data_out_reg;
    assign rsp.ok       = ok_reg;
    assign rsp.count    = count_out_reg;

endmodule
